[rtl/wlm_pkg.sv]
// wildcard list matcher: shared types and constants
// request codes, the decoded command carried by the queue, back-end status
// no dependencies
package wlm_pkg;

  // request codes of the input channel
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_NAME   = 2'd2,
    REQ_END    = 2'd3
  } req_t;

  // decoded request as it sits in the queue
  typedef struct packed {
    req_t       op;
    logic [7:0] ch;    // character, letters folded to lower case
    logic       dlm;   // space, semicolon or zero byte
    logic       star;
    logic       qm;
  } cmd_t;

  // back-end status seen by the top level
  typedef struct packed {
    logic full;
    logic ovf;
    logic busy;
    logic act_any;
    logic end_pop;
  } back_stat_t;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

endpackage

[rtl/wlm_ifs.sv]
// wildcard list matcher: channel interfaces
// request, result and configuration-write channels with valid/ready
// no dependencies
interface wlm_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  modport source (output valid, req_type, char_code, input ready);
  modport sink (input valid, req_type, char_code, output ready);
endinterface

interface wlm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_too_long;
  modport source (output valid, matched, pattern_too_long, input ready);
  modport sink (input valid, matched, pattern_too_long, output ready);
endinterface

interface wlm_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

[rtl/wlm_front.sv]
// wildcard list matcher: front end, accepts requests and classifies them
// depends on wlm_pkg and wlm_in_if
module wlm_front (
  wlm_in_if.sink          in_req,
  output logic            push_valid,
  input  logic            push_ready,
  output wlm_pkg::cmd_t   push_data
);
  import wlm_pkg::*;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_QMARK   = 8'h3F;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFS   = 8'h20;

  // ascii case folding
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      return c + CASE_OFS;
    end
    return c;
  endfunction

  // handshake goes straight through to the queue
  assign in_req.ready = push_ready;
  assign push_valid   = in_req.valid;

  // classify the character
  always_comb begin
    push_data.op   = req_t'(in_req.req_type);
    push_data.ch   = fold_char(in_req.char_code);
    push_data.dlm  = (in_req.char_code == CH_SPACE) || (in_req.char_code == CH_SEMI) ||
                     (in_req.char_code == CH_NUL);
    push_data.star = (in_req.char_code == CH_STAR);
    push_data.qm   = (in_req.char_code == CH_QMARK);
  end

endmodule

[rtl/wlm_queue.sv]
// wildcard list matcher: short queue of decoded requests between front and back
// depends on wlm_pkg
module wlm_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  wlm_pkg::cmd_t   push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output wlm_pkg::cmd_t   pop_data
);
  import wlm_pkg::*;

  cmd_t               q_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               push_fire, pop_fire;

  assign push_ready = (cnt_r != Q_CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = q_r[rd_ptr_r];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = push_fire ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop_fire ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_fire && !pop_fire) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_fire && pop_fire) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/wlm_back.sv]
// wildcard list matcher: back end, pattern store and position-set automaton
// depends on wlm_pkg
module wlm_back #(
  parameter int MAX_PATTERN = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 empty_match_all,
  input  logic                 pop_valid,
  output logic                 pop_ready,
  input  wlm_pkg::cmd_t        pop_data,
  output logic                 res_valid,
  input  logic                 res_ready,
  output logic                 res_matched,
  output logic                 res_too_long,
  output wlm_pkg::back_stat_t  stat
);
  import wlm_pkg::*;

  localparam int W     = MAX_PATTERN + 1;
  localparam int IDX_W = $clog2(MAX_PATTERN);
  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int LVL   = $clog2(W);

  // pattern store: one cell per position
  logic [7:0]             lit_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] star_r, star_nxt;
  logic [MAX_PATTERN-1:0] qm_r, qm_nxt;
  logic [MAX_PATTERN-1:0] dlm_r, dlm_nxt;
  logic [MAX_PATTERN-1:0] live_r, live_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                   ovf_r, ovf_nxt;

  // automaton state
  logic                   busy_r, busy_nxt;
  logic [W-1:0]           act_r, act_nxt;
  logic [W-1:0]           start_r, start_nxt;

  // result register
  logic                   res_valid_r, res_valid_nxt;
  logic                   matched_r, matched_nxt;
  logic                   too_long_r, too_long_nxt;

  logic [IDX_W-1:0]       wr_idx;
  logic                   wr_en;
  logic                   fire;
  logic                   full;
  logic [MAX_PATTERN-1:0] star_l, dlm_l, step_l, eq;
  logic [W-1:0]           base, adv, adv_cl, end_v;
  logic                   acc;

  // star closure: a star may match nothing, so activity runs on through
  // every stretch of stars (parallel prefix over the position vector)
  function automatic logic [W-1:0] close_stars(input logic [W-1:0] s,
                                               input logic [MAX_PATTERN-1:0] st);
    logic [W-1:0] g;
    logic [W-1:0] p;
    g = s;
    p = {st, 1'b0};
    for (int k = 0; k < LVL; k++) begin
      g = g | (p & (g << (1 << k)));
      p = p & (p << (1 << k));
    end
    return g;
  endfunction

  assign wr_idx = cnt_r[IDX_W-1:0];
  assign full   = live_r[MAX_PATTERN-1];
  assign star_l = star_r & live_r;
  assign dlm_l  = dlm_r & live_r;

  // per-position compare against the name character
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      eq[i] = (lit_r[i] == pop_data.ch);
    end
  end

  // one name-character step of the automaton
  assign step_l = live_r & ~dlm_r & ~star_r & (qm_r | eq);
  assign base   = busy_r ? act_r : start_r;
  assign adv    = {1'b0, base[MAX_PATTERN-1:0] & star_l} |
                  {base[MAX_PATTERN-1:0] & step_l, 1'b0};
  assign adv_cl = close_stars(adv, star_l);

  // accepting: active at the end of the list or before a delimiter
  assign end_v = {1'b1, ~live_r} & {live_r, 1'b1};
  assign acc   = |(act_r & (end_v | {1'b0, dlm_l}));

  assign pop_ready = (pop_data.op != REQ_END) || !res_valid_r || res_ready;
  assign fire      = pop_valid && pop_ready;

  // command execution
  always_comb begin
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    act_nxt       = act_r;
    live_nxt      = live_r;
    star_nxt      = star_r;
    qm_nxt        = qm_r;
    dlm_nxt       = dlm_r;
    res_valid_nxt = res_valid_r;
    matched_nxt   = matched_r;
    too_long_nxt  = too_long_r;
    wr_en         = 1'b0;
    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end
    if (fire) begin
      case (pop_data.op)
        REQ_CLEAR: begin
          cnt_nxt  = '0;
          ovf_nxt  = 1'b0;
          act_nxt  = '0;
          live_nxt = '0;
        end
        REQ_APPEND: begin
          if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            wr_en   = 1'b1;
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        REQ_NAME: begin
          busy_nxt = 1'b1;
          act_nxt  = adv_cl;
        end
        REQ_END: begin
          res_valid_nxt = 1'b1;
          too_long_nxt  = ovf_r;
          if (!busy_r) begin
            matched_nxt = 1'b0;
          end else if (!live_r[0]) begin
            matched_nxt = empty_match_all;
          end else begin
            matched_nxt = acc;
          end
          busy_nxt = 1'b0;
          act_nxt  = '0;
        end
        default: begin
        end
      endcase
    end
    // cell flags for an append
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (wr_en && (wr_idx == IDX_W'(i))) begin
        live_nxt[i] = 1'b1;
        star_nxt[i] = pop_data.star;
        qm_nxt[i]   = pop_data.qm;
        dlm_nxt[i]  = pop_data.dlm;
      end
    end
  end

  // start set of the list as it will stand: first byte of every pattern
  always_comb begin
    logic [MAX_PATTERN-1:0] first;
    first     = live_nxt & ~dlm_nxt &
                {dlm_nxt[MAX_PATTERN-2:0] & live_nxt[MAX_PATTERN-2:0], 1'b1};
    start_nxt = close_stars({1'b0, first}, star_nxt & live_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      act_r       <= '0;
      live_r      <= '0;
      start_r     <= '0;
      res_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      act_r       <= act_nxt;
      live_r      <= live_nxt;
      start_r     <= start_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    star_r     <= star_nxt;
    qm_r       <= qm_nxt;
    dlm_r      <= dlm_nxt;
    matched_r  <= matched_nxt;
    too_long_r <= too_long_nxt;
    if (wr_en) begin
      lit_r[wr_idx] <= pop_data.ch;
    end
  end

  assign res_valid    = res_valid_r;
  assign res_matched  = matched_r;
  assign res_too_long = too_long_r;

  // status for checks
  assign stat.full    = full;
  assign stat.ovf     = ovf_r;
  assign stat.busy    = busy_r;
  assign stat.act_any = |act_r;
  assign stat.end_pop = fire && (pop_data.op == REQ_END);

endmodule

[rtl/wildcard_list_matcher_unit.sv]
// Wildcard list matcher. Takes one request per clock, sustained, unless an
// end-of-name request meets a result still waiting on the output: pattern bytes
// build a list of space- or semicolon-separated patterns ('?' one byte, '*' any
// run, letters case-insensitive), name bytes advance a set of active pattern
// positions, and an end-of-name request returns one result (matched and the
// sticky pattern-too-long flag). With nothing queued ahead, a request passes
// through a queue entry and then the back end's result register before the
// result is valid on the output. The rate is set by the back end, which updates
// the whole position set for each name byte; a two-entry request queue lets the
// input keep flowing while a finished result waits on the output, until the
// queue fills. The store holds MAX_PATTERN bytes; no clearing pass is needed after reset.
// depends on wlm_pkg, wlm_ifs, wlm_front, wlm_queue, wlm_back
module wildcard_list_matcher_unit #(
  parameter int MAX_PATTERN = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  wlm_in_if.sink      in_req,
  wlm_out_if.source   out_res,
  wlm_cfg_if.sink     cfg_wr
);
  import wlm_pkg::*;

  logic       empty_all_r;
  logic       push_valid, push_ready;
  cmd_t       push_data;
  logic       pop_valid, pop_ready;
  cmd_t       pop_data;
  logic       res_valid, res_matched, res_too_long;
  back_stat_t stat;

  // configuration register
  assign cfg_wr.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      empty_all_r <= 1'b0;
    end else if (cfg_wr.valid) begin
      empty_all_r <= cfg_wr.data;
    end
  end

  // front end
  wlm_front u_front (
    .in_req     (in_req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // request queue
  wlm_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // back end
  wlm_back #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .empty_match_all (empty_all_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_data        (pop_data),
    .res_valid       (res_valid),
    .res_ready       (out_res.ready),
    .res_matched     (res_matched),
    .res_too_long    (res_too_long),
    .stat            (stat)
  );

  assign out_res.valid            = res_valid;
  assign out_res.matched          = res_matched;
  assign out_res.pattern_too_long = res_too_long;

  // checks
  a_ovf_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    stat.ovf |-> stat.full)
    else $error("overflow flag set while the store has room");

  a_idle_no_active: assert property (@(posedge clk) disable iff (!rst_n)
    !stat.busy |-> !stat.act_any)
    else $error("active positions outside a name");

  a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_res.valid) |-> $past(stat.end_pop))
    else $error("result appeared without an end-of-name request");

endmodule
